// ===== hdl/stlr_pkg.sv =====
// Shared types, constants and helpers for the sorted table linear resampler.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package stlr_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CFG_IDX_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PPM       = 3'd0,
        REG_SCALE_Z   = 3'd1,
        REG_SCALE_BX  = 3'd2,
        REG_SCALE_BY  = 3'd3,
        REG_SCALE_BZ  = 3'd4,
        REG_ROT_COS   = 3'd5,
        REG_ROT_SIN   = 3'd6,
        REG_TRANS_Z   = 3'd7
    } cfg_reg_e;

    localparam logic [15:0]        PPM_RESET   = 16'd100;
    localparam logic signed [31:0] SCALE_ONE   = 32'sh0100_0000;
    localparam logic signed [31:0] ROT_ONE     = 32'sh4000_0000;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_FEW   = 2'd2,
        ST_RANGE = 2'd3
    } status_e;

    typedef struct packed {
        cmd_e               cmd;
        logic signed [31:0] z;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic [15:0]        idx;
    } item_t;

    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
        logic signed [31:0] first_z;
        logic signed [31:0] last_z;
        logic signed [31:0] step_z;
        logic [15:0]        count;
        logic               last;
        status_e            status;
    } result_t;

    typedef struct packed {
        logic signed [31:0] z;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } point_t;

    typedef struct packed {
        logic [15:0]        ppm;
        logic signed [31:0] scale_z;
        logic signed [31:0] scale_bx;
        logic signed [31:0] scale_by;
        logic signed [31:0] scale_bz;
        logic signed [31:0] rot_cos;
        logic signed [31:0] rot_sin;
        logic signed [31:0] trans_z;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_MZ,
        S_INS_MX,
        S_INS_MY,
        S_INS_MB,
        S_INS_R1,
        S_INS_R2,
        S_INS_R3,
        S_INS_R4,
        S_INS_R5,
        S_INS_SRD,
        S_INS_SCMP,
        S_INS_WR,
        S_SMP_MUL,
        S_SMP_CNT,
        S_SMP_DIV,
        S_SMP_OFF1,
        S_SMP_OFF2,
        S_CUR_RD,
        S_CUR_CK,
        S_WALK_RD,
        S_WALK_CK,
        S_W_DIV,
        S_LX,
        S_LY,
        S_LZ,
        S_PUSH
    } eng_state_e;

    // Clamp a wide signed value into 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        begin
            if (v > SAT_MAX)
            begin
                r = 32'sh7FFF_FFFF;
            end
            else if (v < SAT_MIN)
            begin
                r = 32'sh8000_0000;
            end
            else
            begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/stlr_front.sv =====
// Front end: accepts items, classifies the command and holds them in a two-entry queue.
// Depends on stlr_pkg.
`timescale 1ns / 1ps

module stlr_front
    import stlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        command,
    input  logic [31:0] point_z,
    input  logic [31:0] point_bx,
    input  logic [31:0] point_by,
    input  logic [31:0] point_bz,
    input  logic [15:0] sample_index,
    output logic        item_valid,
    output item_t       item,
    input  logic        item_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    item_t       in_item;
    logic        do_push, do_pop;

    always_comb
    begin
        in_item.cmd = command ? CMD_SAMPLE : CMD_INSERT;
        in_item.z   = point_z;
        in_item.bx  = point_bx;
        in_item.by  = point_by;
        in_item.bz  = point_bz;
        // sample index means nothing to an insert; drop it
        in_item.idx = command ? sample_index : 16'd0;
    end

    assign full       = (fill_reg == 2'd2);
    assign item_valid = (fill_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/stlr_divider.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on stlr_pkg.
`timescale 1ns / 1ps

module stlr_divider
    import stlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] rem_sh;
    logic [32:0] diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[63]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = 32'd0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hdl/stlr_result_queue.sv =====
// Two-entry result queue between the engine and the result ports.
// Depends on stlr_pkg.
`timescale 1ns / 1ps

module stlr_result_queue
    import stlr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res_in,
    output logic    res_full,
    output logic    empty,
    input  logic    pop,
    output result_t res_out
);

    result_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        do_push, do_pop;

    assign res_full = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign res_out  = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== hdl/stlr_engine.sv =====
// Back end: point table memory, sorted insert, grid computation, cursor walk and
// interpolation over one shared multiplier and the divider. Depends on stlr_pkg.
`timescale 1ns / 1ps

module stlr_engine
    import stlr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     item_valid,
    input  item_t    item,
    output logic     item_pop,
    input  logic     res_full,
    output logic     res_push,
    output result_t  res,
    output div_req_t div_req,
    input  div_rsp_t div_rsp
);

    point_t point_mem [TABLE_DEPTH];
    point_t rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    point_t            mem_wdata;

    eng_state_e state_reg, state_next;
    item_t      item_reg, item_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic signed [31:0] first_reg, first_next;
    logic signed [31:0] last_reg, last_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [65:0] acc_reg, acc_next;

    logic signed [31:0] zs_reg, zs_next;
    logic signed [31:0] bxs_reg, bxs_next;
    logic signed [31:0] bys_reg, bys_next;
    logic signed [31:0] bzs_reg, bzs_next;
    logic signed [31:0] rx_reg, rx_next;
    logic signed [31:0] ry_reg, ry_next;

    logic [31:0] span_reg, span_next;
    logic [31:0] gcount_reg, gcount_next;
    logic [47:0] step_reg, step_next;
    logic [47:0] off_reg, off_next;
    point_t      lo_reg, lo_next;
    point_t      hi_reg, hi_next;
    logic [30:0] w_reg, w_next;
    result_t     res_reg, res_next;

    logic [CNT_W-1:0]   pos_dec, cnt_dec;
    logic signed [65:0] sh24, rot_diff, rot_sum, lerp_part;
    logic signed [32:0] zt_sum;
    logic [31:0]        gc, rd_zoff, lo_zoff;
    logic [47:0]        rd_zoff48;
    logic [47:0]        t_val;

    always_comb
    begin
        pos_dec   = pos_reg - CNT_W'(1);
        cnt_dec   = count_reg - CNT_W'(1);
        sh24      = prod_reg >>> 24;
        rot_diff  = (acc_reg - prod_reg) >>> 30;
        rot_sum   = (acc_reg + prod_reg) >>> 30;
        lerp_part = prod_reg >>> 31;
        zt_sum    = {zs_reg[31], zs_reg} + {cfg.trans_z[31], cfg.trans_z};
        gc        = prod_reg[47:16];
        rd_zoff   = rd_data_reg.z - first_reg;
        lo_zoff   = lo_reg.z - first_reg;
        rd_zoff48 = {rd_zoff, 16'd0};
        t_val     = off_reg - {lo_zoff, 16'd0};
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        pos_next    = pos_reg;
        acc_next    = acc_reg;
        zs_next     = zs_reg;
        bxs_next    = bxs_reg;
        bys_next    = bys_reg;
        bzs_next    = bzs_reg;
        rx_next     = rx_reg;
        ry_next     = ry_reg;
        span_next   = span_reg;
        gcount_next = gcount_reg;
        step_next   = step_reg;
        off_next    = off_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        w_next      = w_reg;
        res_next    = res_reg;

        mul_a       = '0;
        mul_b       = '0;
        rd_addr     = '0;
        mem_we      = 1'b0;
        mem_addr    = pos_reg[ADDR_W-1:0];
        mem_wdata   = rd_data_reg;
        item_pop    = 1'b0;
        res_push    = 1'b0;
        div_req     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && !res_full)
                begin
                    item_pop  = 1'b1;
                    item_next = item;
                    res_next  = '0;
                    if (item.cmd == CMD_INSERT)
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_PUSH;
                        end
                        else
                        begin
                            state_next = S_INS_MZ;
                        end
                    end
                    else if (count_reg < CNT_W'(2))
                    begin
                        res_next.status = ST_FEW;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        span_next  = last_reg - first_reg;
                        state_next = S_SMP_MUL;
                    end
                end
            end

            S_INS_MZ:
            begin
                mul_a      = {item_reg.z[31], item_reg.z};
                mul_b      = {cfg.scale_z[31], cfg.scale_z};
                state_next = S_INS_MX;
            end

            S_INS_MX:
            begin
                zs_next    = sat32(sh24);
                mul_a      = {item_reg.bx[31], item_reg.bx};
                mul_b      = {cfg.scale_bx[31], cfg.scale_bx};
                state_next = S_INS_MY;
            end

            S_INS_MY:
            begin
                bxs_next   = sat32(sh24);
                mul_a      = {item_reg.by[31], item_reg.by};
                mul_b      = {cfg.scale_by[31], cfg.scale_by};
                state_next = S_INS_MB;
            end

            S_INS_MB:
            begin
                bys_next   = sat32(sh24);
                mul_a      = {item_reg.bz[31], item_reg.bz};
                mul_b      = {cfg.scale_bz[31], cfg.scale_bz};
                state_next = S_INS_R1;
            end

            S_INS_R1:
            begin
                bzs_next   = sat32(sh24);
                mul_a      = {bxs_reg[31], bxs_reg};
                mul_b      = {cfg.rot_cos[31], cfg.rot_cos};
                state_next = S_INS_R2;
            end

            S_INS_R2:
            begin
                acc_next   = prod_reg;
                mul_a      = {bys_reg[31], bys_reg};
                mul_b      = {cfg.rot_sin[31], cfg.rot_sin};
                state_next = S_INS_R3;
            end

            S_INS_R3:
            begin
                rx_next    = sat32(rot_diff);
                mul_a      = {bxs_reg[31], bxs_reg};
                mul_b      = {cfg.rot_sin[31], cfg.rot_sin};
                state_next = S_INS_R4;
            end

            S_INS_R4:
            begin
                acc_next   = prod_reg;
                mul_a      = {bys_reg[31], bys_reg};
                mul_b      = {cfg.rot_cos[31], cfg.rot_cos};
                state_next = S_INS_R5;
            end

            S_INS_R5:
            begin
                ry_next    = sat32(rot_sum);
                zs_next    = sat32({{33{zt_sum[32]}}, zt_sum});
                pos_next   = count_reg;
                state_next = S_INS_SRD;
            end

            S_INS_SRD:
            begin
                if (pos_reg == '0)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    rd_addr    = pos_dec[ADDR_W-1:0];
                    state_next = S_INS_SCMP;
                end
            end

            S_INS_SCMP:
            begin
                // move the larger neighbor up one place
                if (rd_data_reg.z > zs_reg)
                begin
                    mem_we     = 1'b1;
                    mem_addr   = pos_reg[ADDR_W-1:0];
                    mem_wdata  = rd_data_reg;
                    pos_next   = pos_dec;
                    state_next = S_INS_SRD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_we       = 1'b1;
                mem_addr     = pos_reg[ADDR_W-1:0];
                mem_wdata.z  = zs_reg;
                mem_wdata.bx = rx_reg;
                mem_wdata.by = ry_reg;
                mem_wdata.bz = bzs_reg;
                if (pos_reg == '0)
                begin
                    first_next = zs_reg;
                end
                if (pos_reg == count_reg)
                begin
                    last_next = zs_reg;
                end
                count_next  = count_reg + CNT_W'(1);
                cursor_next = '0;
                state_next  = S_PUSH;
            end

            S_SMP_MUL:
            begin
                mul_a      = {1'b0, span_reg};
                mul_b      = {17'd0, cfg.ppm};
                state_next = S_SMP_CNT;
            end

            S_SMP_CNT:
            begin
                gcount_next      = gc;
                res_next.first_z = first_reg;
                res_next.last_z  = last_reg;
                res_next.count   = (gc > 32'd65535) ? 16'hFFFF : gc[15:0];
                if (gc < 32'd2)
                begin
                    res_next.status = ST_FEW;
                    state_next      = S_PUSH;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {16'd0, span_reg, 16'd0};
                    div_req.divisor  = gc - 32'd1;
                    state_next       = S_SMP_DIV;
                end
            end

            S_SMP_DIV:
            begin
                if (div_rsp.done)
                begin
                    step_next       = div_rsp.quotient[47:0];
                    res_next.step_z = div_rsp.quotient[47:16];
                    if ({16'd0, item_reg.idx} >= gcount_reg)
                    begin
                        res_next.status = ST_RANGE;
                        state_next      = S_PUSH;
                    end
                    else
                    begin
                        res_next.last = ({16'd0, item_reg.idx} == (gcount_reg - 32'd1));
                        mul_a         = {17'd0, item_reg.idx};
                        mul_b         = {1'b0, div_rsp.quotient[31:0]};
                        state_next    = S_SMP_OFF1;
                    end
                end
            end

            S_SMP_OFF1:
            begin
                acc_next   = prod_reg;
                mul_a      = {17'd0, item_reg.idx};
                mul_b      = {17'd0, step_reg[47:32]};
                state_next = S_SMP_OFF2;
            end

            S_SMP_OFF2:
            begin
                off_next   = acc_reg[47:0] + {prod_reg[15:0], 32'd0};
                state_next = S_CUR_RD;
            end

            S_CUR_RD:
            begin
                rd_addr    = cursor_reg;
                state_next = S_CUR_CK;
            end

            S_CUR_CK:
            begin
                // a request that goes backwards rewinds the cursor
                if (({1'b0, cursor_reg} >= count_reg) || (rd_zoff48 > off_reg))
                begin
                    cursor_next = '0;
                    state_next  = S_CUR_RD;
                end
                else
                begin
                    lo_next    = rd_data_reg;
                    pos_next   = {1'b0, cursor_reg} + CNT_W'(1);
                    state_next = S_WALK_RD;
                end
            end

            S_WALK_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    // nothing above the target: hold the final entry
                    cursor_next = cnt_dec[ADDR_W-1:0];
                    res_next.bx = lo_reg.bx;
                    res_next.by = lo_reg.by;
                    res_next.bz = lo_reg.bz;
                    state_next  = S_PUSH;
                end
                else
                begin
                    rd_addr    = pos_reg[ADDR_W-1:0];
                    state_next = S_WALK_CK;
                end
            end

            S_WALK_CK:
            begin
                if (rd_zoff48 > off_reg)
                begin
                    hi_next          = rd_data_reg;
                    cursor_next      = pos_dec[ADDR_W-1:0];
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, t_val, 15'd0};
                    div_req.divisor  = rd_data_reg.z - lo_reg.z;
                    state_next       = S_W_DIV;
                end
                else
                begin
                    lo_next    = rd_data_reg;
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_WALK_RD;
                end
            end

            S_W_DIV:
            begin
                if (div_rsp.done)
                begin
                    w_next     = div_rsp.quotient[30:0];
                    mul_a      = {hi_reg.bx[31], hi_reg.bx} - {lo_reg.bx[31], lo_reg.bx};
                    mul_b      = {2'd0, div_rsp.quotient[30:0]};
                    state_next = S_LX;
                end
            end

            S_LX:
            begin
                res_next.bx = lo_reg.bx + lerp_part[31:0];
                mul_a       = {hi_reg.by[31], hi_reg.by} - {lo_reg.by[31], lo_reg.by};
                mul_b       = {2'd0, w_reg};
                state_next  = S_LY;
            end

            S_LY:
            begin
                res_next.by = lo_reg.by + lerp_part[31:0];
                mul_a       = {hi_reg.bz[31], hi_reg.bz} - {lo_reg.bz[31], lo_reg.bz};
                mul_b       = {2'd0, w_reg};
                state_next  = S_LZ;
            end

            S_LZ:
            begin
                res_next.bz = lo_reg.bz + lerp_part[31:0];
                state_next  = S_PUSH;
            end

            S_PUSH:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        pos_reg    <= pos_next;
        prod_reg   <= mul_a * mul_b;
        acc_reg    <= acc_next;
        zs_reg     <= zs_next;
        bxs_reg    <= bxs_next;
        bys_reg    <= bys_next;
        bzs_reg    <= bzs_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        span_reg   <= span_next;
        gcount_reg <= gcount_next;
        step_reg   <= step_next;
        off_reg    <= off_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        w_reg      <= w_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            point_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= point_mem[rd_addr];
    end

endmodule

// ===== hdl/sorted_table_linear_resampler.sv =====
// Top level of the sorted table linear resampler: configuration registers, front end,
// engine, divider and result queue. Depends on stlr_pkg and all stlr_* modules.
`timescale 1ns / 1ps

// The block keeps up to 256 field points (z, bx, by, bz) sorted by z and answers
// regular-grid sample requests by linear interpolation. Both sides behave as queues:
// push an item while full is low, pop a result while empty is low; every item gives
// exactly one result. Items are carried out one at a time by the engine. An insert
// moves each stored point with larger z up one place (one table memory port, one
// read or write a cycle). A sample runs two divisions (grid step, then interpolation
// weight) on the one-bit-a-cycle divider, which dominate its time, and its products
// go through the shared 33x33 multiplier; the cursor walk adds time for each stored
// point it passes. Requests with rising index reuse the cursor, so a forward sweep
// walks the table once. Requests that end early (table full, too few points, index
// out of range) skip the cursor walk and the interpolation. The front queue holds two
// items and the result queue two results, so short stalls on either side are absorbed;
// a lasting result stall fills both queues and raises full.
// Configuration (cfg_write, cfg_index, cfg_data) takes effect at once; write it only
// while the block is idle.

module sorted_table_linear_resampler
    import stlr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic [31:0]          point_z,
    input  logic [31:0]          point_bx,
    input  logic [31:0]          point_by,
    input  logic [31:0]          point_bz,
    input  logic [15:0]          sample_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          sample_bx,
    output logic [31:0]          sample_by,
    output logic [31:0]          sample_bz,
    output logic [31:0]          first_z,
    output logic [31:0]          last_z,
    output logic [31:0]          step_z,
    output logic [15:0]          sample_count,
    output logic                 last_flag,
    output logic [1:0]           status
);

    cfg_t     cfg_reg, cfg_next;
    logic     item_valid, item_pop;
    item_t    item;
    logic     res_push, res_full;
    result_t  res_in, res_out;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // Decode the register index; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PPM:      cfg_next.ppm      = cfg_data[15:0];
                REG_SCALE_Z:  cfg_next.scale_z  = cfg_data;
                REG_SCALE_BX: cfg_next.scale_bx = cfg_data;
                REG_SCALE_BY: cfg_next.scale_by = cfg_data;
                REG_SCALE_BZ: cfg_next.scale_bz = cfg_data;
                REG_ROT_COS:  cfg_next.rot_cos  = cfg_data;
                REG_ROT_SIN:  cfg_next.rot_sin  = cfg_data;
                REG_TRANS_Z:  cfg_next.trans_z  = cfg_data;
                default:      cfg_next          = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ppm      <= PPM_RESET;
            cfg_reg.scale_z  <= SCALE_ONE;
            cfg_reg.scale_bx <= SCALE_ONE;
            cfg_reg.scale_by <= SCALE_ONE;
            cfg_reg.scale_bz <= SCALE_ONE;
            cfg_reg.rot_cos  <= ROT_ONE;
            cfg_reg.rot_sin  <= 32'sd0;
            cfg_reg.trans_z  <= 32'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept and queue incoming items.
    stlr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .command      (command),
        .point_z      (point_z),
        .point_bx     (point_bx),
        .point_by     (point_by),
        .point_bz     (point_bz),
        .sample_index (sample_index),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    // Carry out one item at a time against the point table.
    stlr_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res_in),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    // Shared divider for grid step and interpolation weight.
    stlr_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Hold finished results until the consumer pops them.
    stlr_result_queue u_result_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign sample_bx    = res_out.bx;
    assign sample_by    = res_out.by;
    assign sample_bz    = res_out.bz;
    assign first_z      = res_out.first_z;
    assign last_z       = res_out.last_z;
    assign step_z       = res_out.step_z;
    assign sample_count = res_out.count;
    assign last_flag    = res_out.last;
    assign status       = res_out.status;

endmodule

// ===== bench/sorted_table_linear_resampler_tb.sv =====
// Self-checking regression bench for the sorted table linear resampler.
// Holds a bit-true predictor of the point table and grid sampler; depends on stlr_pkg and the RTL.
`timescale 1ns / 1ps

module sorted_table_linear_resampler_tb
    import stlr_pkg::*;
();

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 command = 1'b0;
    logic [31:0]          point_z = '0;
    logic [31:0]          point_bx = '0;
    logic [31:0]          point_by = '0;
    logic [31:0]          point_bz = '0;
    logic [15:0]          sample_index = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [31:0]          sample_bx;
    logic [31:0]          sample_by;
    logic [31:0]          sample_bz;
    logic [31:0]          first_z;
    logic [31:0]          last_z;
    logic [31:0]          step_z;
    logic [15:0]          sample_count;
    logic                 last_flag;
    logic [1:0]           status;

    sorted_table_linear_resampler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .command      (command),
        .point_z      (point_z),
        .point_bx     (point_bx),
        .point_by     (point_by),
        .point_bz     (point_bz),
        .sample_index (sample_index),
        .empty        (empty),
        .pop          (pop),
        .sample_bx    (sample_bx),
        .sample_by    (sample_by),
        .sample_bz    (sample_bz),
        .first_z      (first_z),
        .last_z       (last_z),
        .step_z       (step_z),
        .sample_count (sample_count),
        .last_flag    (last_flag),
        .status       (status)
    );

    // Stimulus and expectation stores.
    item_t   pending_items[$];
    result_t expected_results[$];
    item_t   cur_item;
    int      mismatches = 0;

    // Idle mix of the current phase, in percent.
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      phase_no = 0;
    logic    pop_hold = 1'b0;

    // Shadow copy of the point table and registers.
    logic signed [31:0] tbl_z  [TABLE_DEPTH];
    logic signed [31:0] tbl_bx [TABLE_DEPTH];
    logic signed [31:0] tbl_by [TABLE_DEPTH];
    logic signed [31:0] tbl_bz [TABLE_DEPTH];
    int      stored_points = 0;
    int      cursor_pos = 0;
    longint  m_ppm = 100;
    longint  m_scale_z = 16777216;
    longint  m_scale_bx = 16777216;
    longint  m_scale_by = 16777216;
    longint  m_scale_bz = 16777216;
    longint  m_cos = 1073741824;
    longint  m_sin = 0;
    longint  m_trans = 0;

    // Sweep state for grid index generation.
    int      sweep_idx = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Append one item to the tail of the stimulus queue.
    task automatic add_item(item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint z_above_first(int k);
        return longint'(tbl_z[k]) - longint'(tbl_z[0]);
    endfunction

    function automatic logic [31:0] blend(logic signed [31:0] lo, logic signed [31:0] hi,
                                          longint w);
        longint d;
        longint v;
        d = longint'(hi) - longint'(lo);
        v = longint'(lo) + ((d * w) >>> 31);
        return v[31:0];
    endfunction

    // Apply one item to the shadow table and return the result it should produce.
    function automatic result_t resample_item(item_t it);
        result_t r;
        longint  z, bx, by, bz, rx, ry;
        longint  span, grid, step32, off, t, dz, w, idx;
        int      pos, n, k;
        bit      found;
        r = '0;
        if (it.cmd == CMD_INSERT)
        begin
            if (stored_points >= TABLE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                z  = clamp32((longint'(it.z) * m_scale_z) >>> 24);
                bx = clamp32((longint'(it.bx) * m_scale_bx) >>> 24);
                by = clamp32((longint'(it.by) * m_scale_by) >>> 24);
                bz = clamp32((longint'(it.bz) * m_scale_bz) >>> 24);
                rx = clamp32((bx * m_cos - by * m_sin) >>> 30);
                ry = clamp32((bx * m_sin + by * m_cos) >>> 30);
                z  = clamp32(z + m_trans);
                pos = stored_points;
                // Shift larger z up one place; equal z stays below the new point.
                while (pos > 0 && longint'(tbl_z[pos-1]) > z)
                begin
                    tbl_z[pos]  = tbl_z[pos-1];
                    tbl_bx[pos] = tbl_bx[pos-1];
                    tbl_by[pos] = tbl_by[pos-1];
                    tbl_bz[pos] = tbl_bz[pos-1];
                    pos--;
                end
                tbl_z[pos]  = z[31:0];
                tbl_bx[pos] = rx[31:0];
                tbl_by[pos] = ry[31:0];
                tbl_bz[pos] = bz[31:0];
                stored_points++;
                cursor_pos = 0;
            end
        end
        else if (stored_points < 2)
        begin
            r.status = ST_FEW;
        end
        else
        begin
            n = stored_points;
            span = z_above_first(n - 1);
            grid = (span * m_ppm) >> 16;
            idx = longint'(it.idx);
            r.first_z = tbl_z[0];
            r.last_z  = tbl_z[n-1];
            r.count   = (grid > 65535) ? 16'hFFFF : grid[15:0];
            if (grid < 2)
            begin
                r.status = ST_FEW;
            end
            else
            begin
                step32 = (span << 16) / (grid - 1);
                r.step_z = step32[47:16];
                if (idx >= grid)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    off = idx * step32;
                    // Rewind the cursor on a backward request.
                    if (cursor_pos >= n || (z_above_first(cursor_pos) << 16) > off)
                    begin
                        cursor_pos = 0;
                    end
                    found = 1'b0;
                    for (k = cursor_pos + 1; k < n; k++)
                    begin
                        if ((z_above_first(k) << 16) > off)
                        begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found)
                    begin
                        dz = longint'(tbl_z[k]) - longint'(tbl_z[k-1]);
                        t  = off - (z_above_first(k - 1) << 16);
                        w  = (t << 15) / dz;
                        cursor_pos = k - 1;
                        r.bx = blend(tbl_bx[k-1], tbl_bx[k], w);
                        r.by = blend(tbl_by[k-1], tbl_by[k], w);
                        r.bz = blend(tbl_bz[k-1], tbl_bz[k], w);
                    end
                    else
                    begin
                        // Target sits at or past the last point: take its field.
                        cursor_pos = n - 1;
                        r.bx = tbl_bx[n-1];
                        r.by = tbl_by[n-1];
                        r.bz = tbl_bz[n-1];
                    end
                    r.last = (idx == grid - 1);
                end
            end
        end
        return r;
    endfunction

    // Driver: account for the accepted item, then offer the next one or idle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_results.insert(expected_results.size(), resample_item(cur_item));
            end
            if (!push || !full)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = pending_items.pop_front();
                    push         <= 1'b1;
                    command      <= cur_item.cmd;
                    point_z      <= cur_item.z;
                    point_bx     <= cur_item.bx;
                    point_by     <= cur_item.by;
                    point_bz     <= cur_item.bz;
                    sample_index <= cur_item.idx;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Monitor: check the popped result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result popped with nothing expected");
                    mismatches++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    compare_field("sample_bx", e.bx, sample_bx);
                    compare_field("sample_by", e.by, sample_by);
                    compare_field("sample_bz", e.bz, sample_bz);
                    compare_field("first_z", e.first_z, first_z);
                    compare_field("last_z", e.last_z, last_z);
                    compare_field("step_z", e.step_z, step_z);
                    compare_field("sample_count", 32'(e.count), 32'(sample_count));
                    compare_field("last_flag", 32'(e.last), 32'(last_flag));
                    compare_field("status", 32'(e.status), 32'(status));
                end
            end
            pop <= !pop_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off in the third phase so the block backs up and stalls push.
    initial
    begin
        wait (phase_no == 2);
        @(posedge clk);
        pop_hold <= 1'b1;
        repeat (3000) @(posedge clk);
        pop_hold <= 1'b0;
    end

    function automatic item_t insert_item(logic [31:0] z, logic [31:0] bx,
                                          logic [31:0] by, logic [31:0] bz);
        item_t it;
        it.cmd = CMD_INSERT;
        it.z   = z;
        it.bx  = bx;
        it.by  = by;
        it.bz  = bz;
        it.idx = 16'($urandom);
        return it;
    endfunction

    function automatic item_t sample_item(logic [15:0] idx);
        item_t it;
        it.cmd = CMD_SAMPLE;
        it.z   = $urandom;
        it.bx  = $urandom;
        it.by  = $urandom;
        it.bz  = $urandom;
        it.idx = idx;
        return it;
    endfunction

    // Queue one phase of random items: inserts at insert_pct percent, the rest mostly forward sweeps.
    task automatic queue_random(int count, int insert_pct, int wide_z_pct);
        logic [31:0] z;
        int          roll;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < insert_pct)
            begin
                if ($urandom_range(99) < wide_z_pct)
                begin
                    z = $urandom;
                end
                else
                begin
                    z = 32'($signed($urandom_range(2 * 1048576)) - 1048576);
                end
                add_item(insert_item(z, $urandom, $urandom, $urandom));
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    add_item(sample_item(16'($urandom)));
                end
                else
                begin
                    // Restart the sweep now and then, sometimes backwards.
                    if (roll < 20)
                    begin
                        sweep_idx = $urandom_range(200);
                    end
                    add_item(sample_item(16'(sweep_idx)));
                    sweep_idx += $urandom_range(1, 40);
                end
            end
        end
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [31:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_PPM:      m_ppm      = longint'(v[15:0]);
            REG_SCALE_Z:  m_scale_z  = longint'($signed(v));
            REG_SCALE_BX: m_scale_bx = longint'($signed(v));
            REG_SCALE_BY: m_scale_by = longint'($signed(v));
            REG_SCALE_BZ: m_scale_bz = longint'($signed(v));
            REG_ROT_COS:  m_cos      = longint'($signed(v));
            REG_ROT_SIN:  m_sin      = longint'($signed(v));
            REG_TRANS_Z:  m_trans    = longint'($signed(v));
            default: ;
        endcase
    endtask

    // Hold until every queued item is in and every expected result is out.
    task automatic drain();
        while (pending_items.size() > 0 || push || expected_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic set_idle(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty table, single point, zero grid, equal z, sweep ends,
        // out of range, backward request, mid-table insert.
        set_idle(0, 0);
        add_item(sample_item(16'd0));
        add_item(insert_item(32'h0, 32'h0100_0000, 32'h0, 32'hFF00_0000));
        add_item(sample_item(16'd0));
        add_item(insert_item(32'h100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
        add_item(sample_item(16'd0));
        add_item(insert_item(32'h100, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        add_item(insert_item(32'h3_0000, 32'h0200_0000, 32'hFE00_0000, 32'h7FFF_FFFF));
        add_item(sample_item(16'd0));
        add_item(sample_item(16'd1));
        add_item(sample_item(16'd150));
        add_item(sample_item(16'd299));
        add_item(sample_item(16'd300));
        add_item(sample_item(16'hFFFF));
        add_item(sample_item(16'd10));
        add_item(insert_item(32'h1_8000, 32'h1234_5678, 32'h8765_4321, 32'h8000_0000));
        add_item(sample_item(16'd50));
        add_item(sample_item(16'd51));
        add_item(insert_item(32'hFFFF_0000, 32'h0, 32'h0, 32'h0));
        add_item(sample_item(16'd0));
        add_item(sample_item(16'd398));
        add_item(sample_item(16'd399));
        drain();

        // Sender idles often; finer grid.
        phase_no = 1;
        write_reg(REG_PPM, 32'd1000);
        set_idle(74, 0);
        queue_random(130, 30, 0);
        drain();

        // Receiver stalls, with a long hold-off; mild rotation and scaling.
        phase_no = 2;
        write_reg(REG_PPM, 32'd100);
        write_reg(REG_SCALE_BX, 32'h0180_0000);
        write_reg(REG_SCALE_BY, 32'hFF40_0000);
        write_reg(REG_SCALE_BZ, 32'h0080_0000);
        write_reg(REG_ROT_COS, 32'h2D41_3CCD);
        write_reg(REG_ROT_SIN, 32'h2D41_3CCD);
        write_reg(REG_TRANS_Z, 32'h0002_0000);
        set_idle(0, 74);
        queue_random(130, 30, 0);
        drain();

        // Both sides idle; coarsest grid and extreme field scales and rotation.
        phase_no = 3;
        write_reg(REG_PPM, 32'd1);
        write_reg(REG_SCALE_BX, 32'h8000_0000);
        write_reg(REG_SCALE_BY, 32'h7FFF_FFFF);
        write_reg(REG_SCALE_BZ, 32'h8000_0000);
        write_reg(REG_ROT_COS, 32'hC000_0000);
        write_reg(REG_ROT_SIN, 32'h4000_0000);
        write_reg(REG_TRANS_Z, 32'hFFFF_0000);
        set_idle(20, 20);
        queue_random(130, 30, 0);
        drain();

        // No idling; finest grid, saturating z scale and offset.
        phase_no = 4;
        write_reg(REG_PPM, 32'd65535);
        write_reg(REG_SCALE_Z, 32'h7FFF_FFFF);
        write_reg(REG_TRANS_Z, 32'h8000_0000);
        write_reg(REG_SCALE_BX, 32'h0100_0000);
        write_reg(REG_ROT_COS, 32'h4000_0000);
        write_reg(REG_ROT_SIN, 32'hC000_0000);
        set_idle(0, 0);
        queue_random(110, 30, 20);
        drain();

        // Fill the table past capacity with extreme z, then sample the full table.
        phase_no = 5;
        write_reg(REG_SCALE_Z, 32'h8000_0000);
        write_reg(REG_TRANS_Z, 32'h7FFF_FFFF);
        write_reg(REG_PPM, 32'd100);
        set_idle(20, 20);
        add_item(insert_item(32'h7FFF_FFFF, $urandom, $urandom, $urandom));
        add_item(insert_item(32'h8000_0000, $urandom, $urandom, $urandom));
        drain();
        write_reg(REG_SCALE_Z, 32'h0100_0000);
        write_reg(REG_TRANS_Z, 32'h0);
        queue_random(120, 100, 30);
        queue_random(40, 0, 0);
        drain();

        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("sorted_table_linear_resampler regression: pass");
        end
        else
        begin
            $display("sorted_table_linear_resampler regression: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("sorted_table_linear_resampler regression: fail");
        $finish;
    end

endmodule
